// File: rtl/izh_pkg.sv
// shared types and constants for the neuron update block
package izh_pkg;

	localparam int unsigned IndexW = 10;
	localparam int unsigned DataW = 32;
	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DT_C    = 3'd0,
		REG_DT_A    = 3'd1,
		REG_K       = 3'd2,
		REG_B       = 3'd3,
		REG_VR      = 3'd4,
		REG_VT      = 3'd5,
		REG_V_RESET = 3'd6,
		REG_D       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]        dt_c;
		logic [31:0]        dt_a;
		logic signed [31:0] k;
		logic signed [31:0] b;
		logic signed [31:0] vr;
		logic signed [31:0] vt;
		logic signed [31:0] v_reset;
		logic signed [31:0] d;
	} cfg_t;

	localparam logic signed [31:0] SatMax = 32'sh7fffffff;
	localparam logic signed [31:0] SatMin = 32'sh80000000;

	// clip a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (x > 34'sh07fffffff) r = SatMax;
		else if (x < -34'sh080000000) r = SatMin;
		return r;
	endfunction

	function automatic logic ovf34(input logic signed [33:0] x);
		return (x > 34'sh07fffffff) || (x < -34'sh080000000);
	endfunction

	// clip a 72-bit signed value to 32 bits
	function automatic logic signed [31:0] sat72(input logic signed [71:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (x > 72'sh007fffffff) r = SatMax;
		else if (x < -72'sh0080000000) r = SatMin;
		return r;
	endfunction

	function automatic logic ovf72(input logic signed [71:0] x);
		return (x > 72'sh007fffffff) || (x < -72'sh0080000000);
	endfunction

endpackage

// File: rtl/izh_if.sv
// valid/ready channel interfaces for items, results and configuration writes
interface izh_in_if;
	import izh_pkg::*;
	logic valid;
	logic ready;
	logic [IndexW-1:0] neuron_index;
	logic signed [DataW-1:0] input_current;
	modport source (output valid, neuron_index, input_current, input ready);
	modport sink (input valid, neuron_index, input_current, output ready);
endinterface

interface izh_out_if;
	import izh_pkg::*;
	logic valid;
	logic ready;
	logic [IndexW-1:0] result_index;
	logic spike;
	logic signed [DataW-1:0] new_potential;
	logic saturated;
	modport source (output valid, result_index, spike, new_potential, saturated, input ready);
	modport sink (input valid, result_index, spike, new_potential, saturated, output ready);
endinterface

interface izh_cfg_if;
	import izh_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [DataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/izh_ram.sv
// generic single-write, single-read ram with registered read data
module izh_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// File: rtl/izhikevich_neuron_update_top.sv
// top level: neuron state stores, clearing pass and euler-step pipeline
// throughput: one neuron per cycle; an item for a neuron still in stages 1 to 7
// waits until that update is in stage 8, and a stall freezes the whole pipeline
// reset: arst_n clears control and loads register reset values, then a clearing
// pass zeroes both stores while no item is taken
module izhikevich_neuron_update_top
	import izh_pkg::*;
#(
	parameter int unsigned NEURON_COUNT = 1024,
	parameter logic signed [31:0] PEAK_POTENTIAL = 32'sd1966080
) (
	input logic clk,
	input logic arst_n,
	izh_in_if.sink   in_ch,
	izh_out_if.source out_ch,
	izh_cfg_if.sink  cfg_ch
);
	localparam int unsigned AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
	localparam int unsigned NS = 9;

	// configuration registers
	cfg_t cfg_q;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dt_c    <= 32'd17179869;
			cfg_q.dt_a    <= 32'd42949673;
			cfg_q.k       <= 32'sd41943040;
			cfg_q.b       <= -32'sd33554432;
			cfg_q.vr      <= -32'sd3932160;
			cfg_q.vt      <= -32'sd1258291;
			cfg_q.v_reset <= -32'sd4259840;
			cfg_q.d       <= 32'sd13107200;
		end else if (cfg_ch.valid) begin
			unique case (reg_idx_t'(cfg_ch.index))
				REG_DT_C:    cfg_q.dt_c    <= cfg_ch.data;
				REG_DT_A:    cfg_q.dt_a    <= cfg_ch.data;
				REG_K:       cfg_q.k       <= cfg_ch.data;
				REG_B:       cfg_q.b       <= cfg_ch.data;
				REG_VR:      cfg_q.vr      <= cfg_ch.data;
				REG_VT:      cfg_q.vt      <= cfg_ch.data;
				REG_V_RESET: cfg_q.v_reset <= cfg_ch.data;
				default:     cfg_q.d       <= cfg_ch.data;
			endcase
		end
	end

	// clearing pass
	logic          clr_q;
	logic [AW:0]   clr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == (AW+1)'(NEURON_COUNT - 1)) clr_q <= 1'b0;
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// pipeline control: whole pipe advances when output is free
	logic adv;
	logic hazard;
	logic [NS:1] vld;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv && !clr_q && !hazard;
	wire take = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else if (adv) vld <= {vld[NS-1:1], take};
	end

	// stage payload
	logic [IndexW-1:0] idx_s [1:NS];
	logic              inr_s [1:NS];
	logic signed [31:0] cur_s [1:NS];
	logic signed [31:0] v_s [2:NS];
	logic signed [31:0] u_s [2:NS];

	wire in_range = 32'(in_ch.neuron_index) < NEURON_COUNT;

	// hold a neuron back while its previous update is too early to forward
	always_comb begin
		hazard = 1'b0;
		for (int i = 1; i <= NS-2; i++) begin
			if (vld[i] && idx_s[i] == in_ch.neuron_index) hazard = 1'b1;
		end
	end

	// stores
	logic signed [31:0] v_rd, u_rd;
	logic wb_we;
	logic [AW-1:0] wb_addr;
	logic signed [31:0] wb_v, wb_u;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0] ram_v, ram_u;
	assign ram_we    = clr_q || wb_we;
	assign ram_waddr = clr_q ? clr_cnt_q[AW-1:0] : wb_addr;
	assign ram_v     = clr_q ? 32'd0 : wb_v;
	assign ram_u     = clr_q ? 32'd0 : wb_u;

	izh_ram #(.Width(32), .Depth(NEURON_COUNT)) u_vram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_v),
		.re(take), .raddr(in_ch.neuron_index[AW-1:0]), .rdata(v_rd));
	izh_ram #(.Width(32), .Depth(NEURON_COUNT)) u_uram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_u),
		.re(take), .raddr(in_ch.neuron_index[AW-1:0]), .rdata(u_rd));

	// write-back results held in later stages, for forwarding
	logic signed [31:0] nv_s9, nu_s9;
	logic sp_s9, sat_s9;
	// history of recent writes (covers read latency window)
	localparam int unsigned HW = NS;
	logic              hv_q [HW];
	logic [IndexW-1:0] hi_q [HW];
	logic signed [31:0] hvv_q [HW];
	logic signed [31:0] huu_q [HW];

	// stage 2: pick stored or forwarded state (newest write wins)
	logic signed [31:0] v_fw, u_fw;
	always_comb begin
		v_fw = v_rd;
		u_fw = u_rd;
		for (int i = HW-1; i >= 0; i--) begin
			if (hv_q[i] && hi_q[i] == idx_s[1]) begin
				v_fw = hvv_q[i];
				u_fw = huu_q[i];
			end
		end
		if (wb_we && idx_s[NS] == idx_s[1]) begin
			v_fw = wb_v;
			u_fw = wb_u;
		end
	end

	// history of writes: stored when the item leaves the last stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HW; i++) hv_q[i] <= 1'b0;
		end else if (adv) begin
			hv_q[0] <= wb_we;
			for (int i = 1; i < HW; i++) hv_q[i] <= hv_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hi_q[0] <= idx_s[NS]; hvv_q[0] <= wb_v; huu_q[0] <= wb_u;
			for (int i = 1; i < HW; i++) begin
				hi_q[i] <= hi_q[i-1]; hvv_q[i] <= hvv_q[i-1]; huu_q[i] <= huu_q[i-1];
			end
		end
	end

	// datapath registers
	logic signed [31:0] e1_s3, e2_s3;
	logic f_s3, f_s4, f_s5, f_s6, f_s7, f_s8;
	logic signed [63:0] p_s4, bp_s4;
	logic signed [31:0] q_s5, w_s5;
	logic signed [63:0] kq_s6;
	logic signed [31:0] r_s6;
	logic signed [31:0] s_s7, r_s7;
	logic signed [65:0] ms_s8, mr_s8;

	wire signed [33:0] e1w = 34'(v_s[2]) - 34'(cfg_q.vr);
	wire signed [33:0] e2w = 34'(v_s[2]) - 34'(cfg_q.vt);
	wire signed [71:0] qw = (72'(p_s4) + 72'sd32768) >>> 16;
	wire signed [71:0] ww = (72'(bp_s4) + 72'sd8388608) >>> 24;
	wire signed [71:0] tw = (72'(kq_s6) + 72'sd8388608) >>> 24;
	wire signed [31:0] t6 = sat72(tw);
	wire signed [33:0] sw = 34'(t6) - 34'(u_s[6]) + 34'(cur_s[6]);
	wire signed [33:0] rw = 34'(w_s5) - 34'(u_s[5]);
	wire signed [71:0] dvw = (72'(ms_s8) + 72'sh80000000) >>> 32;
	wire signed [71:0] duw = (72'(mr_s8) + 72'sh80000000) >>> 32;
	wire signed [71:0] nvw = 72'(v_s[8]) + dvw;
	wire signed [71:0] nuw = 72'(u_s[8]) + duw;

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: memory read in flight, capture item
			idx_s[1] <= in_ch.neuron_index;
			inr_s[1] <= in_range;
			cur_s[1] <= in_ch.input_current;
			for (int i = 2; i <= NS; i++) begin
				idx_s[i] <= idx_s[i-1];
				inr_s[i] <= inr_s[i-1];
				cur_s[i] <= cur_s[i-1];
			end
			v_s[2] <= v_fw;
			u_s[2] <= u_fw;
			for (int i = 3; i <= NS; i++) begin
				v_s[i] <= v_s[i-1];
				u_s[i] <= u_s[i-1];
			end
			// s3: differences
			e1_s3 <= sat34(e1w);
			e2_s3 <= sat34(e2w);
			f_s3  <= ovf34(e1w) || ovf34(e2w);
			// s4: products
			p_s4  <= e1_s3 * e2_s3;
			bp_s4 <= cfg_q.b * e1_s3;
			f_s4  <= f_s3;
			// s5: round q and w
			q_s5 <= sat72(qw);
			w_s5 <= sat72(ww);
			f_s5 <= f_s4 || ovf72(qw) || ovf72(ww);
			// s6: k*q, r
			kq_s6 <= cfg_q.k * q_s5;
			r_s6  <= sat34(rw);
			f_s6  <= f_s5 || ovf34(rw);
			// s7: s
			s_s7 <= sat34(sw);
			r_s7 <= r_s6;
			f_s7 <= f_s6 || ovf72(tw) || ovf34(sw);
			// s8: dt products
			ms_s8 <= $signed({34'd0, cfg_q.dt_c}) * 66'(s_s7);
			mr_s8 <= $signed({34'd0, cfg_q.dt_a}) * 66'(r_s7);
			f_s8  <= f_s7;
		end
	end

	// s9: new state and spike
	always_ff @(posedge clk) begin
		logic signed [31:0] nv, nu;
		logic signed [33:0] nud;
		logic f, sp;
		if (adv) begin
			nv = sat72(nvw);
			nu = sat72(nuw);
			f  = f_s8 || ovf72(nvw) || ovf72(nuw);
			sp = nv >= PEAK_POTENTIAL;
			if (sp) begin
				nud = 34'(nu) + 34'(cfg_q.d);
				nv  = cfg_q.v_reset;
				nu  = sat34(nud);
				f   = f || ovf34(nud);
			end
			nv_s9  <= nv;
			nu_s9  <= nu;
			sp_s9  <= sp;
			sat_s9 <= f;
		end
	end

	// write-back at the advance edge that retires the last stage
	assign wb_we   = vld[NS] && inr_s[NS] && adv;
	assign wb_addr = idx_s[NS][AW-1:0];
	assign wb_v    = nv_s9;
	assign wb_u    = nu_s9;

	// output register
	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= vld[NS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.result_index  <= idx_s[NS];
			out_ch.spike         <= inr_s[NS] && sp_s9;
			out_ch.new_potential <= inr_s[NS] ? nv_s9 : 32'sd0;
			out_ch.saturated     <= inr_s[NS] && sat_s9;
		end
	end
	assign out_ch.valid = ov_q;

`ifndef NO_ASSERTIONS
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ch.ready) else $error("item taken during clear");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable(vld)) else $error("pipe moved in stall");
	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wb_we |-> vld[NS]) else $error("write without item");
`endif
endmodule

// File: verif/testbench.sv
// self-checking testbench for the izhikevich neuron update block
`timescale 1ns / 100ps

module testbench;
	import izh_pkg::*;

	localparam int unsigned Neurons = 1024;
	localparam longint PeakMv = 1966080;
	localparam int unsigned IdleLimit = 6000;
	localparam int unsigned LongHold = 300;
	localparam int unsigned TypedRows = 3;
	localparam int unsigned RandomPhases = 8;
	localparam int unsigned ItemsPerPhase = 190;

	typedef struct packed {
		logic [IndexW-1:0] idx;
		logic              spike;
		logic [31:0]       pot;
		logic              sat;
	} neuron_result_t;

	typedef struct packed {
		logic [IndexW-1:0] idx;
		logic [31:0]       cur;
		logic              typed;
		logic              spike;
		logic [31:0]       pot;
		logic              sat;
	} stim_row_t;

	logic clk;
	logic arst_n;

	izh_in_if  in_ch ();
	izh_out_if out_ch ();
	izh_cfg_if cfg_ch ();

	izhikevich_neuron_update_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// predictor copy of registers and neuron state
	cfg_t        model_cfg;
	logic signed [31:0] membrane_mv [Neurons];
	logic signed [31:0] recovery_mv [Neurons];
	neuron_result_t pending_results [$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned spikes_seen;
	int unsigned clips_seen;
	int unsigned items_sent;
	int unsigned idle_cycles;
	bit          stim_done;
	bit          no_idle;
	bit          long_hold_req;
	bit          long_hold_taken;
	int unsigned hold_left;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// clip to signed 32 bits, flagging any clip
	function automatic longint clip32(input longint x, inout bit clipped);
		if (x > 64'sd2147483647) begin
			clipped = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			clipped = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// round to nearest, ties up, then drop n fraction bits
	function automatic longint round_drop(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// one euler step of a neuron, updating the predictor state
	function automatic neuron_result_t euler_step(input logic [IndexW-1:0] idx,
			input logic signed [31:0] cur);
		neuron_result_t res;
		bit clipped;
		longint v, u, e1, e2, q, t, s, nv, w, r, nu, dtc, dta;
		clipped = 1'b0;
		v = membrane_mv[idx];
		u = recovery_mv[idx];
		dtc = longint'({32'b0, model_cfg.dt_c});
		dta = longint'({32'b0, model_cfg.dt_a});
		e1 = clip32(v - longint'(model_cfg.vr), clipped);
		e2 = clip32(v - longint'(model_cfg.vt), clipped);
		q = clip32(round_drop(e1 * e2, 16), clipped);
		t = clip32(round_drop(longint'(model_cfg.k) * q, 24), clipped);
		s = clip32(t - u + longint'(cur), clipped);
		nv = clip32(v + round_drop(dtc * s, 32), clipped);
		w = clip32(round_drop(longint'(model_cfg.b) * e1, 24), clipped);
		r = clip32(w - u, clipped);
		nu = clip32(u + round_drop(dta * r, 32), clipped);
		res.spike = 1'b0;
		if (nv >= PeakMv) begin
			res.spike = 1'b1;
			nv = longint'(model_cfg.v_reset);
			nu = clip32(nu + longint'(model_cfg.d), clipped);
		end
		membrane_mv[idx] = nv[31:0];
		recovery_mv[idx] = nu[31:0];
		res.idx = idx;
		res.pot = nv[31:0];
		res.sat = clipped;
		return res;
	endfunction

	// random gap: mostly none, some short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one item and predict its result at transfer
	task automatic send_item(input logic [IndexW-1:0] idx, input logic [31:0] cur,
			input bit typed, input neuron_result_t typed_res);
		neuron_result_t res;
		int unsigned gap;
		in_ch.valid <= 1'b1;
		in_ch.neuron_index <= idx;
		in_ch.input_current <= cur;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		res = euler_step(idx, cur);
		pending_results.push_back(typed ? typed_res : res);
		items_sent++;
		gap = gap_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register write, only issued while nothing is in flight
	task automatic write_reg(input reg_idx_t ridx, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= ridx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (ridx)
			REG_DT_C:    model_cfg.dt_c = data;
			REG_DT_A:    model_cfg.dt_a = data;
			REG_K:       model_cfg.k = data;
			REG_B:       model_cfg.b = data;
			REG_VR:      model_cfg.vr = data;
			REG_VT:      model_cfg.vt = data;
			REG_V_RESET: model_cfg.v_reset = data;
			REG_D:       model_cfg.d = data;
			default:     ;
		endcase
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_all(input cfg_t c);
		write_reg(REG_DT_C, c.dt_c);
		write_reg(REG_DT_A, c.dt_a);
		write_reg(REG_K, c.k);
		write_reg(REG_B, c.b);
		write_reg(REG_VR, c.vr);
		write_reg(REG_VT, c.vt);
		write_reg(REG_V_RESET, c.v_reset);
		write_reg(REG_D, c.d);
	endtask

	// random current: mostly moderate drive, some full range and extremes
	function automatic logic [31:0] pick_current();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return ((int'($urandom_range(0, 2400)) - 400) <<< 16) + $urandom_range(0, 65535);
		if (r < 85) return $urandom;
		if (r < 90) return 32'h7fffffff;
		if (r < 95) return 32'h80000000;
		return 32'h0;
	endfunction

	// sink side ready with random stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			long_hold_taken <= 1'b0;
		end else if (long_hold_req && !long_hold_taken) begin
			long_hold_taken <= 1'b1;
			hold_left <= LongHold;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 99) < 35) begin
				out_ch.ready <= 1'b0;
				hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 2);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		neuron_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (out_ch.spike) spikes_seen++;
			if (out_ch.saturated) clips_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: index %0d", out_ch.result_index);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result_index !== want.idx || out_ch.spike !== want.spike ||
						out_ch.new_potential !== want.pot || out_ch.saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx %0d spk %0d v %h sat %0d, got idx %0d spk %0d v %h sat %0d",
							want.idx, want.spike, want.pot, want.sat, out_ch.result_index,
							out_ch.spike, out_ch.new_potential, out_ch.saturated);
				end
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("izhikevich_neuron_update_top verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		stim_row_t rows [];
		neuron_result_t typed_res;
		cfg_t c;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.neuron_index = '0;
		in_ch.input_current = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DT_C;
		cfg_ch.data = '0;
		items_sent = 0;
		stim_done = 1'b0;
		no_idle = 1'b0;
		long_hold_req = 1'b0;
		model_cfg.dt_c = 32'd17179869;
		model_cfg.dt_a = 32'd42949673;
		model_cfg.k = 32'sd41943040;
		model_cfg.b = -32'sd33554432;
		model_cfg.vr = -32'sd3932160;
		model_cfg.vt = -32'sd1258291;
		model_cfg.v_reset = -32'sd4259840;
		model_cfg.d = 32'sd13107200;
		for (int i = 0; i < Neurons; i++) begin
			membrane_mv[i] = '0;
			recovery_mv[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first rows with zero step sizes keep v at zero
		rows = '{
			'{10'd0,    32'h7fffffff, 1'b1, 1'b0, 32'h0, 1'b1},
			'{10'd1023, 32'h80000000, 1'b1, 1'b0, 32'h0, 1'b0},
			'{10'd3,    32'h00000000, 1'b1, 1'b0, 32'h0, 1'b0},
			'{10'd0,    32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd0,    32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1,    32'h7fffffff, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1,    32'h7fffffff, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1,    32'h7fffffff, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd2,    32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd2,    32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1023, 32'h03e80000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1023, 32'h03e80000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd512,  32'hffff0000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd341,  32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd682,  32'h55555555, 1'b0, 1'b0, 32'h0, 1'b0},
			'{10'd1,    32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0}
		};
		write_reg(REG_DT_C, 32'h0);
		write_reg(REG_DT_A, 32'h0);
		foreach (rows[i]) begin
			if (i == TypedRows) begin
				wait_drained();
				write_reg(REG_DT_C, 32'd17179869);
				write_reg(REG_DT_A, 32'd42949673);
			end
			typed_res = '{rows[i].idx, rows[i].spike, rows[i].pot, rows[i].sat};
			send_item(rows[i].idx, rows[i].cur, rows[i].typed, typed_res);
		end

		// random phases under changing register settings
		for (int p = 0; p < RandomPhases; p++) begin
			wait_drained();
			no_idle = (p == 1);
			c = model_cfg;
			case (p)
				2: c = '{32'hffffffff, 32'hffffffff, 32'sh80000000, 32'sh7fffffff,
					32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
				3: c = '{32'h0, 32'h0, 32'sh7fffffff, 32'sh80000000,
					32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
				4, 5: c = '{$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
				6: c = '{32'd17179869, 32'd42949673, 32'sd41943040, -32'sd33554432,
					-32'sd3932160, -32'sd1258291, -32'sd4259840, 32'sd13107200};
				7: c = '{32'd85899346, 32'd4294967, 32'sd16777216, 32'sd3355443,
					-32'sd4587520, -32'sd2621440, -32'sd3276800, 32'sd524288};
				default: ;
			endcase
			write_all(c);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				if (p == 6 && n == 20) long_hold_req = 1'b1;
				send_item(IndexW'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 15)
					: $urandom), pick_current(), 1'b0, '0);
			end
		end

		// drain and settle
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
		for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0d results never arrived", pending_results.size());
		$display("sent %0d items, checked %0d results (%0d spikes, %0d clipped)",
			items_sent, results_seen, spikes_seen, clips_seen);
		$display("%0d register settings incl. extremes, one long output hold; %0d mismatches",
			RandomPhases + 2, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("izhikevich_neuron_update_top verification clean");
		else
			$display("izhikevich_neuron_update_top verification failed");
		$finish;
	end

endmodule

// File: izhikevich_neuron_update_top.f
rtl/izh_pkg.sv
rtl/izh_if.sv
rtl/izh_ram.sv
rtl/izhikevich_neuron_update_top.sv
verif/testbench.sv
